FILE: rtl/core/ree_pkg.sv
// Shared types, constants and helpers for the rational expression evaluator.
`default_nettype none
package ree_pkg;

	localparam int OP_DEPTH    = 16;
	localparam int VALUE_DEPTH = 16;
	localparam int OP_AW       = $clog2(OP_DEPTH);
	localparam int OP_CW       = $clog2(OP_DEPTH + 1);
	localparam int VAL_AW      = $clog2(VALUE_DEPTH);
	localparam int VAL_CW      = $clog2(VALUE_DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int DW          = 64;

	typedef enum logic [OP_W-1:0] {
		OPC_ADD  = 3'd0,
		OPC_SUB  = 3'd1,
		OPC_MUL  = 3'd2,
		OPC_DIV  = 3'd3,
		OPC_LPAR = 3'd4
	} op_code_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADCHAR  = 3'd1;
	localparam logic [2:0] ST_SYNTAX   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_ZEROGCD  = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} char_t;

	typedef struct packed {
		logic signed [DW-1:0] numerator;
		logic signed [DW-1:0] denominator;
		logic [2:0]           status;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_FLUSH,
		S_OPTOP,
		S_OPCHK,
		S_RED0,
		S_RED1,
		S_RED2,
		S_MUL,
		S_MULW,
		S_WB,
		S_ENDTOP,
		S_ENDCHK,
		S_RD0,
		S_GCHK,
		S_GWAIT,
		S_QN,
		S_QD,
		S_OUT
	} state_t;

	function automatic logic [1:0] prec(input op_code_t code);
		logic [1:0] p;
		p = 2'd0;
		if (code == OPC_MUL || code == OPC_DIV)
			p = 2'd2;
		else if (code == OPC_ADD || code == OPC_SUB)
			p = 2'd1;
		return p;
	endfunction

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (DW'(0) - v) : v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rational_expression_evaluator_top.sv
// Top level: shunting-yard parser and fraction evaluator over RAM-based stacks.
`default_nettype none
// Takes one ASCII character per transaction and returns one result transaction
// after the character flagged last. An operator may look at the stack top and
// reduces each pending operator it has to (two value-stack reads, three products
// on the shared 32x32 multiplier, one write-back, one more look at the stack
// top). The closing normalization runs Euclid's algorithm on the 64-bit
// bit-serial divider, followed by two more divisions. A new character is
// accepted while the previous result still waits in the output register.
module rational_expression_evaluator_top import ree_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_ready,
	input  wire char_t char_item,
	output logic       res_valid,
	input  wire logic  res_ready,
	output res_t       res_item
);
	state_t state_q, state_d;
	logic [OP_CW-1:0]  op_cnt_q, op_cnt_d;
	logic [VAL_CW-1:0] val_cnt_q, val_cnt_d;
	logic [DW-1:0]     lit_q, lit_d;
	logic              in_lit_q, in_lit_d;
	logic [2:0]        fault_q, fault_d;
	logic              fin_q, fin_d;
	logic              res_valid_q, res_valid_d;
	char_t             char_q, char_d;
	op_code_t          cur_op_q, cur_op_d, red_op_q, red_op_d;
	logic              is_rpar_q, is_rpar_d;
	logic [1:0]        k_q, k_d;
	logic [DW-1:0]     a1_q, a1_d, b1_q, b1_d, a2_q, a2_d, b2_q, b2_d;
	logic [DW-1:0]     p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
	logic [DW-1:0]     x_q, x_d, y_q, y_d, n_q, n_d, d_q, d_d;
	res_t              res_q, res_d;

	logic                op_we;
	logic [OP_AW-1:0]    op_waddr, op_raddr;
	logic [OP_W-1:0]     op_rdata;
	logic                val_we;
	logic [VAL_AW-1:0]   val_waddr, val_raddr;
	logic [2*DW-1:0]     val_wdata, val_rdata;
	logic                mul_start, mul_done;
	logic [DW-1:0]       mul_a, mul_b, mul_prod;
	logic                div_start, div_done;
	logic [DW-1:0]       div_num, div_den, div_quo, div_rem;
	logic [DW-1:0]       red_n, red_d, lit_base;
	logic [3:0]          digit;
	op_code_t            top_op;
	logic                push_req;
	state_t              ret_state;

	ree_ram #(.WIDTH(OP_W), .DEPTH(OP_DEPTH)) u_op_ram (
		.clk  (clk),
		.we   (op_we),
		.waddr(op_waddr),
		.wdata(OP_W'(cur_op_q)),
		.raddr(op_raddr),
		.rdata(op_rdata)
	);

	ree_ram #(.WIDTH(2*DW), .DEPTH(VALUE_DEPTH)) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.raddr(val_raddr),
		.rdata(val_rdata)
	);

	ree_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	ree_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign op_raddr  = OP_AW'(op_cnt_q - 1'b1);
	assign op_waddr  = op_cnt_q[OP_AW-1:0];
	assign val_waddr = val_cnt_q[VAL_AW-1:0];
	assign top_op    = op_code_t'(op_rdata);
	assign digit     = 4'(char_q.char_code - CH_ZERO);
	assign lit_base  = in_lit_q ? lit_q : '0;
	assign ret_state = fin_q ? S_ENDTOP : S_OPTOP;

	always_comb begin
		val_raddr = '0;
		if (state_q == S_RED0)
			val_raddr = VAL_AW'(val_cnt_q - 1'b1);
		else if (state_q == S_RED1)
			val_raddr = VAL_AW'(val_cnt_q - 2'd2);
	end

	// operand selection for the three products of one reduction
	always_comb begin
		unique case (k_q)
			2'd0: begin
				mul_a = a1_q;
				mul_b = (red_op_q == OPC_MUL) ? a2_q : b2_q;
			end
			2'd1: begin
				mul_a = b1_q;
				mul_b = (red_op_q == OPC_MUL) ? b2_q : a2_q;
			end
			default: begin
				mul_a = b1_q;
				mul_b = b2_q;
			end
		endcase
	end

	always_comb begin
		unique case (red_op_q)
			OPC_ADD: begin
				red_n = p0_q + p1_q;
				red_d = p2_q;
			end
			OPC_SUB: begin
				red_n = p0_q - p1_q;
				red_d = p2_q;
			end
			default: begin
				red_n = p0_q;
				red_d = p1_q;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		op_cnt_d    = op_cnt_q;
		val_cnt_d   = val_cnt_q;
		lit_d       = lit_q;
		in_lit_d    = in_lit_q;
		fault_d     = fault_q;
		fin_d       = fin_q;
		res_valid_d = res_valid_q;
		char_d      = char_q;
		cur_op_d    = cur_op_q;
		red_op_d    = red_op_q;
		is_rpar_d   = is_rpar_q;
		k_d         = k_q;
		a1_d = a1_q; b1_d = b1_q; a2_d = a2_q; b2_d = b2_q;
		p0_d = p0_q; p1_d = p1_q; p2_d = p2_q;
		x_d = x_q; y_d = y_q; n_d = n_q; d_d = d_q;
		res_d       = res_q;
		op_we       = 1'b0;
		val_we      = 1'b0;
		val_wdata   = {red_n, red_d};
		mul_start   = 1'b0;
		div_start   = 1'b0;
		div_num     = mag(x_q);
		div_den     = mag(y_q);
		push_req    = 1'b0;

		if (res_valid_q && res_ready)
			res_valid_d = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					char_d  = char_item;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (fault_q != ST_OK) begin
					if (char_q.last) begin
						fin_d   = 1'b1;
						state_d = S_ENDTOP;
					end
				end else begin
					priority if (char_q.char_code == CH_SPACE) begin
					end else if (char_q.char_code >= CH_ZERO && char_q.char_code <= CH_NINE) begin
						lit_d    = {lit_base[DW-4:0], 3'd0} + {lit_base[DW-2:0], 1'b0}
						           + DW'(digit);
						in_lit_d = 1'b1;
					end else if (char_q.char_code == CH_PLUS) begin
						cur_op_d = OPC_ADD;
					end else if (char_q.char_code == CH_MINUS) begin
						cur_op_d = OPC_SUB;
					end else if (char_q.char_code == CH_STAR) begin
						cur_op_d = OPC_MUL;
					end else if (char_q.char_code == CH_SLASH) begin
						cur_op_d = OPC_DIV;
					end else if (char_q.char_code == CH_LPAR) begin
						cur_op_d = OPC_LPAR;
					end else if (char_q.char_code == CH_RPAR) begin
						cur_op_d = OPC_LPAR;
					end else begin
						fault_d = ST_BADCHAR;
					end
					is_rpar_d = (char_q.char_code == CH_RPAR);
					if (char_q.char_code == CH_PLUS || char_q.char_code == CH_MINUS ||
					    char_q.char_code == CH_STAR || char_q.char_code == CH_SLASH ||
					    char_q.char_code == CH_LPAR || char_q.char_code == CH_RPAR)
						state_d = S_FLUSH;
					else if (char_q.last) begin
						fin_d   = 1'b1;
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (fault_q == ST_OK && in_lit_q) begin
					if (val_cnt_q >= VAL_CW'(VALUE_DEPTH))
						fault_d = ST_OVERFLOW;
					else begin
						val_we    = 1'b1;
						val_wdata = {lit_q, DW'(1)};
						val_cnt_d = val_cnt_q + 1'b1;
					end
				end
				in_lit_d = 1'b0;
				lit_d    = '0;
				state_d  = ret_state;
			end
			S_OPTOP: begin
				state_d = S_IDLE;
				if (fault_q == ST_OK) begin
					if (cur_op_q == OPC_LPAR && !is_rpar_q)
						push_req = 1'b1;
					else if (op_cnt_q == '0) begin
						if (is_rpar_q)
							fault_d = ST_SYNTAX;
						else
							push_req = 1'b1;
					end else
						state_d = S_OPCHK;
				end
				if (state_d == S_IDLE && char_q.last) begin
					fin_d   = 1'b1;
					state_d = S_FLUSH;
				end
			end
			S_OPCHK: begin
				state_d = S_IDLE;
				if (is_rpar_q && top_op == OPC_LPAR)
					op_cnt_d = op_cnt_q - 1'b1;
				else if (is_rpar_q || prec(top_op) >= prec(cur_op_q)) begin
					op_cnt_d = op_cnt_q - 1'b1;
					red_op_d = top_op;
					state_d  = S_RED0;
				end else
					push_req = 1'b1;
				if (state_d == S_IDLE && char_q.last) begin
					fin_d   = 1'b1;
					state_d = S_FLUSH;
				end
			end
			S_RED0: begin
				if (val_cnt_q < VAL_CW'(2)) begin
					fault_d = ST_SYNTAX;
					state_d = ret_state;
				end else
					state_d = S_RED1;
			end
			S_RED1: begin
				a2_d    = val_rdata[2*DW-1:DW];
				b2_d    = val_rdata[DW-1:0];
				state_d = S_RED2;
			end
			S_RED2: begin
				a1_d      = val_rdata[2*DW-1:DW];
				b1_d      = val_rdata[DW-1:0];
				val_cnt_d = val_cnt_q - VAL_CW'(2);
				k_d       = 2'd0;
				state_d   = S_MUL;
			end
			S_MUL: begin
				mul_start = 1'b1;
				state_d   = S_MULW;
			end
			S_MULW: begin
				if (mul_done) begin
					unique case (k_q)
						2'd0: p0_d = mul_prod;
						2'd1: p1_d = mul_prod;
						default: p2_d = mul_prod;
					endcase
					if (k_q == 2'd2)
						state_d = S_WB;
					else begin
						k_d     = k_q + 2'd1;
						state_d = S_MUL;
					end
				end
			end
			S_WB: begin
				if (val_cnt_q >= VAL_CW'(VALUE_DEPTH))
					fault_d = ST_OVERFLOW;
				else begin
					val_we    = 1'b1;
					val_cnt_d = val_cnt_q + 1'b1;
				end
				state_d = ret_state;
			end
			S_ENDTOP: begin
				if (fault_q != ST_OK)
					state_d = S_OUT;
				else if (op_cnt_q == '0) begin
					if (val_cnt_q != VAL_CW'(1)) begin
						fault_d = ST_SYNTAX;
						state_d = S_OUT;
					end else
						state_d = S_RD0;
				end else
					state_d = S_ENDCHK;
			end
			S_ENDCHK: begin
				if (top_op == OPC_LPAR) begin
					fault_d = ST_SYNTAX;
					state_d = S_OUT;
				end else begin
					op_cnt_d = op_cnt_q - 1'b1;
					red_op_d = top_op;
					state_d  = S_RED0;
				end
			end
			S_RD0: begin
				a1_d    = val_rdata[2*DW-1:DW];
				b1_d    = val_rdata[DW-1:0];
				x_d     = val_rdata[2*DW-1:DW];
				y_d     = val_rdata[DW-1:0];
				state_d = S_GCHK;
			end
			S_GCHK: begin
				if (y_q == '0) begin
					if (x_q == '0) begin
						fault_d = ST_ZEROGCD;
						state_d = S_OUT;
					end else begin
						div_start = 1'b1;
						div_num   = mag(a1_q);
						div_den   = mag(x_q);
						state_d   = S_QN;
					end
				end else begin
					div_start = 1'b1;
					state_d   = S_GWAIT;
				end
			end
			S_GWAIT: begin
				if (div_done) begin
					// remainder takes the sign of the dividend
					y_d     = x_q[DW-1] ? (DW'(0) - div_rem) : div_rem;
					x_d     = y_q;
					state_d = S_GCHK;
				end
			end
			S_QN: begin
				if (div_done) begin
					n_d       = (a1_q[DW-1] != x_q[DW-1]) ? (DW'(0) - div_quo) : div_quo;
					div_start = 1'b1;
					div_num   = mag(b1_q);
					div_den   = mag(x_q);
					state_d   = S_QD;
				end
			end
			S_QD: begin
				if (div_done) begin
					d_d     = (b1_q[DW-1] != x_q[DW-1]) ? (DW'(0) - div_quo) : div_quo;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!res_valid_q || res_ready) begin
					res_d.status      = fault_q;
					res_d.numerator   = (fault_q == ST_OK) ? n_q : '0;
					res_d.denominator = (fault_q == ST_OK) ? d_q : '0;
					res_valid_d       = 1'b1;
					op_cnt_d          = '0;
					val_cnt_d         = '0;
					lit_d             = '0;
					in_lit_d          = 1'b0;
					fault_d           = ST_OK;
					fin_d             = 1'b0;
					state_d           = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (push_req) begin
			if (op_cnt_q >= OP_CW'(OP_DEPTH))
				fault_d = ST_OVERFLOW;
			else begin
				op_we    = 1'b1;
				op_cnt_d = op_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_cnt_q    <= '0;
			val_cnt_q   <= '0;
			lit_q       <= '0;
			in_lit_q    <= 1'b0;
			fault_q     <= ST_OK;
			fin_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_cnt_q    <= op_cnt_d;
			val_cnt_q   <= val_cnt_d;
			lit_q       <= lit_d;
			in_lit_q    <= in_lit_d;
			fault_q     <= fault_d;
			fin_q       <= fin_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q    <= char_d;
		cur_op_q  <= cur_op_d;
		red_op_q  <= red_op_d;
		is_rpar_q <= is_rpar_d;
		k_q       <= k_d;
		a1_q <= a1_d; b1_q <= b1_d; a2_q <= a2_d; b2_q <= b2_d;
		p0_q <= p0_d; p1_q <= p1_d; p2_q <= p2_d;
		x_q <= x_d; y_q <= y_d; n_q <= n_d; d_q <= d_d;
		res_q     <= res_d;
	end

	assign char_ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign res_item   = res_q;
endmodule
`default_nettype wire

FILE: rtl/core/ree_ram.sv
// Generic single-port-write, registered-read RAM for the evaluator stacks.
`default_nettype none
module ree_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/ree_mul.sv
// 64x64 wrapping multiplier built from one 32x32 multiplier.
`default_nettype none
module ree_mul import ree_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a,
	input  wire logic [DW-1:0] b,
	output logic               done,
	output logic      [DW-1:0] prod
);
	logic [DW-1:0] a_q, b_q, pp_q, acc_q;
	logic [1:0]    step_q;
	logic          busy_q, done_q;
	logic [31:0]   ma, mb;
	logic [DW-1:0] pp_w;

	// step 0: lo*lo, step 1: lo*hi, step 2: hi*lo (only low halves of cross terms matter)
	assign ma   = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign mb   = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign pp_w = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			pp_q <= pp_w;
			if (step_q == 2'd1)
				acc_q <= pp_q;
			else if (step_q != 2'd0)
				acc_q <= acc_q + {pp_q[31:0], 32'd0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

FILE: rtl/core/ree_div.sv
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module ree_div import ree_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [DW-1:0] quo,
	output logic      [DW-1:0] rem
);
	logic [DW-1:0]         q_q, r_q, d_q;
	logic [$clog2(DW)-1:0] cnt_q;
	logic                  busy_q, done_q;
	logic [DW:0]           shifted, diff;

	assign shifted = {r_q, q_q[DW-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(DW)'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				r_q <= diff[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= shifted[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire
